[sv/fvwm_pkg.sv]
// Package for the four-voice wavetable mixer: field widths, register and
// function codes, scaling constants and output limits.
// No dependencies.
package fvwm_pkg;

    // Field widths of the input and result words
    localparam int FUNC_W    = 1;
    localparam int VOICE_W   = 2;
    localparam int WADDR_W   = 10;
    localparam int WDATA_W   = 8;
    localparam int OUT_W     = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_VOICES = 4;
    localparam int VSEL_W     = 2;
    localparam int VOL_W      = 7;
    localparam int STEP_W     = 20;

    // Voices that the voice field can address
    localparam int VOICE_SPAN = 1 << VOICE_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_D   = 3'd7;

    localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b1;

    // Scaling: volume * sample / 64, truncated toward zero
    localparam int SCALE_SHIFT = 6;
    localparam int SCALE_DIV   = 1 << SCALE_SHIFT;
    localparam int PROD_W      = VOL_W + 1 + WDATA_W;
    localparam int TERM_W      = 9;

    // Output saturation limits
    localparam int OUT_MIN = -512;
    localparam int OUT_MAX = 511;

endpackage

[sv/fvwm_in_if.sv]
// Input channel of the wavetable mixer: valid/ready plus the request word.
// Depends on fvwm_pkg.
interface fvwm_in_if;
    import fvwm_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [FUNC_W-1:0]           func;
    logic [VOICE_W-1:0]          voice;
    logic [WADDR_W-1:0]          wave_addr;
    logic signed [WDATA_W-1:0]   wave_data;

    modport source (output valid, func, voice, wave_addr, wave_data, input ready);
    modport sink   (input valid, func, voice, wave_addr, wave_data, output ready);
endinterface

[sv/fvwm_out_if.sv]
// Output channel of the wavetable mixer: valid/ready plus the mixed sample.
// Depends on fvwm_pkg.
interface fvwm_out_if;
    import fvwm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [OUT_W-1:0]   mixed_sample;

    modport source (output valid, mixed_sample, input ready);
    modport sink   (input valid, mixed_sample, output ready);
endinterface

[sv/four_voice_wavetable_mixer.sv]
// Four-voice wavetable mixer.
// Input channel i_in carries one word per item. func selects the job:
// a table write stores wave_data at entry wave_addr of the table of voice
// `voice` and makes no result; a sample request makes one word on o_out,
// the saturated sum of volume * sample / 64 over voices with nonzero
// volume, each of which then advances its phase by its step.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write the volumes
// (index 0..3) and steps (index 4..7); the user must write them only while
// the block is idle, which the block does not enforce; a step is folded
// into the phase range as it is written, ready on the next cycle.
// Throughput: one word per cycle unless o_out stalls, tables and samples
// in any mix; each voice reads its own table bank, one read port per voice.
// Reset clears the phases to zero, volumes to zero and steps to 65536;
// table contents are undefined until written.
// When o_out stalls, the three pipeline registers fill in turn and
// i_in.ready drops once all are occupied; no word is lost.
// Depends on fvwm_pkg, fvwm_in_if, fvwm_out_if, fvwm_step_mod.
module four_voice_wavetable_mixer #(
    parameter int VOICES    = 4,
    parameter int WAVE_LEN  = 640,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fvwm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fvwm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    fvwm_in_if.sink                             i_in,
    fvwm_out_if.source                          o_out
);
    import fvwm_pkg::*;

    localparam int AW    = $clog2(WAVE_LEN);
    localparam int PH_W  = AW + FRAC_BITS;
    localparam int AXW   = ((AW > WADDR_W) ? AW : WADDR_W) + 1;
    localparam int SUM_W = TERM_W + $clog2(VOICES) + 1;
    localparam longint LIMIT_L = longint'(WAVE_LEN) << FRAC_BITS;
    localparam logic [PH_W:0]   LIMIT      = (PH_W+1)'(LIMIT_L);
    localparam logic [PH_W-1:0] SRED_RESET = PH_W'(longint'(STEP_RESET) % LIMIT_L);

    // Configuration and voice state; steps are kept folded into the range
    logic [VOL_W-1:0]     r_vol   [VOICES];
    logic [PH_W-1:0]      r_sred  [VOICES];
    logic [PH_W-1:0]      r_phase [VOICES];
    logic [PH_W-1:0]      n_phase [VOICES];
    logic [PH_W:0]        ph_sum  [VOICES];
    logic [PH_W-1:0]      red_rem;

    // Handshake and decode
    logic                 s3_take, s2_free, s1_free;
    logic                 in_acc, is_sample, is_write;
    logic [AXW-1:0]       wa_ext;
    logic                 wa_ok;
    logic [AW-1:0]        wa_idx;

    // Pipeline
    logic                        r_s1_valid;
    logic [VOL_W-1:0]            r_s1_vol  [VOICES];
    logic signed [WDATA_W-1:0]   r_rd      [VOICES];
    logic signed [PROD_W-1:0]    prod      [VOICES];
    logic signed [PROD_W-1:0]    adj       [VOICES];
    logic signed [TERM_W-1:0]    term      [VOICES];
    logic                        r_s2_valid;
    logic signed [TERM_W-1:0]    r_s2_term [VOICES];
    logic signed [SUM_W-1:0]     acc;
    logic signed [OUT_W-1:0]     mixed;
    logic                        r_o_valid;
    logic signed [OUT_W-1:0]     r_o_data;

    // Flow control: each stage moves when the one after it frees up
    assign s3_take   = !r_o_valid || o_out.ready;
    assign s2_free   = !r_s2_valid || s3_take;
    assign s1_free   = !r_s1_valid || s2_free;
    assign i_in.ready = s1_free;
    assign in_acc    = i_in.valid && i_in.ready;
    assign is_sample = (i_in.func == FUNC_SAMPLE);
    assign is_write  = (i_in.func == FUNC_WRITE);

    // Table write address check
    assign wa_ext = AXW'(i_in.wave_addr);
    assign wa_ok  = wa_ext < AXW'(WAVE_LEN);
    assign wa_idx = wa_ext[AW-1:0];

    // Fold the written step into the phase range
    fvwm_step_mod #(
        .WAVE_LEN  (WAVE_LEN),
        .FRAC_BITS (FRAC_BITS)
    ) u_step_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (i_cfg_data[STEP_W-1:0]),
        .o_rem   (red_rem)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_vol[v]  <= '0;
                r_sred[v] <= SRED_RESET;
            end
        end else if (i_cfg_we) begin
            for (int v = 0; v < VOICES; v++) begin
                if (v < CFG_VOICES && i_cfg_idx[VSEL_W-1:0] == VSEL_W'(v)) begin
                    unique case (i_cfg_idx) inside
                        [REG_VOLUME_A:REG_VOLUME_D]: r_vol[v]  <= i_cfg_data[VOL_W-1:0];
                        [REG_STEP_A:REG_STEP_D]:     r_sred[v] <= red_rem;
                        default: ;
                    endcase
                end
            end
        end
    end

    // Advance phases of audible voices, wrap once at the range
    always_comb begin
        for (int v = 0; v < VOICES; v++) begin
            ph_sum[v] = {1'b0, r_phase[v]} + {1'b0, r_sred[v]};
            if (ph_sum[v] >= LIMIT) begin
                ph_sum[v] = ph_sum[v] - LIMIT;
            end
            n_phase[v] = ph_sum[v][PH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_phase[v] <= '0;
            end
        end else if (in_acc && is_sample) begin
            for (int v = 0; v < VOICES; v++) begin
                if (r_vol[v] != '0) begin
                    r_phase[v] <= n_phase[v];
                end
            end
        end
    end

    // One table bank per voice: write port from table words, read at phase
    for (genvar v = 0; v < VOICES; v++) begin : g_bank
        logic signed [WDATA_W-1:0] r_mem [WAVE_LEN];
        logic                      wr_en;

        assign wr_en = in_acc && is_write && wa_ok && (v < VOICE_SPAN)
                       && (i_in.voice == VOICE_W'(v));

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[wa_idx] <= i_in.wave_data;
            end
            if (in_acc && is_sample) begin
                r_rd[v] <= r_mem[r_phase[v][PH_W-1:FRAC_BITS]];
            end
        end
    end

    // Stage 1: table data and volumes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= in_acc && is_sample;
        end
        if (in_acc && is_sample) begin
            r_s1_vol <= r_vol;
        end
    end

    // Scale each voice, rounding toward zero; drop muted voices
    always_comb begin
        for (int v = 0; v < VOICES; v++) begin
            prod[v] = $signed({1'b0, r_s1_vol[v]}) * r_rd[v];
            adj[v]  = prod[v] + (prod[v][PROD_W-1] ? PROD_W'(SCALE_DIV - 1) : '0);
            if (r_s1_vol[v] == '0) begin
                term[v] = '0;
            end else begin
                term[v] = TERM_W'(adj[v] >>> SCALE_SHIFT);
            end
        end
    end

    // Stage 2: scaled terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
        if (s2_free && r_s1_valid) begin
            r_s2_term <= term;
        end
    end

    // Sum the terms and saturate to the output range
    always_comb begin
        acc = '0;
        for (int v = 0; v < VOICES; v++) begin
            acc = acc + SUM_W'(r_s2_term[v]);
        end
        if (acc < SUM_W'(OUT_MIN)) begin
            mixed = OUT_W'(OUT_MIN);
        end else if (acc > SUM_W'(OUT_MAX)) begin
            mixed = OUT_W'(OUT_MAX);
        end else begin
            mixed = OUT_W'(acc);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s3_take) begin
            r_o_valid <= r_s2_valid;
        end
        if (s3_take && r_s2_valid) begin
            r_o_data <= mixed;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.mixed_sample = r_o_data;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.mixed_sample)))
        else $error("output word changed under stall");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_free) |=> r_s1_valid)
        else $error("stage 1 word dropped under stall");

    for (genvar v = 0; v < VOICES; v++) begin : g_chk
        a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            {1'b0, r_phase[v]} < LIMIT)
            else $error("phase left its range");

        a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (in_acc && is_sample && r_vol[v] == '0) |=> $stable(r_phase[v]))
            else $error("silent voice advanced");
    end

endmodule

[sv/fvwm_step_mod.sv]
// Step reducer: folds a written step into the phase range (WAVE_LEN << FRAC_BITS)
// with one reciprocal multiply and one compare and subtract, combinationally.
// Depends on fvwm_pkg.
module fvwm_step_mod #(
    parameter int WAVE_LEN  = 640,
    parameter int FRAC_BITS = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic [fvwm_pkg::STEP_W-1:0]                   i_step,
    output logic [$clog2(WAVE_LEN)+FRAC_BITS-1:0]         o_rem
);
    import fvwm_pkg::*;

    localparam int AW    = $clog2(WAVE_LEN);
    localparam int PH_W  = AW + FRAC_BITS;
    // Whole-entry part of the step and the widths of its arithmetic
    localparam int IW    = (STEP_W > FRAC_BITS) ? STEP_W - FRAC_BITS : 1;
    localparam int MW    = IW + AW + 1;
    localparam int PW    = 2 * IW + 1;
    // floor(2^RSH / WAVE_LEN): the quotient estimate is exact or one low
    localparam int RSH   = IW + AW;
    localparam longint RECIP_L = (longint'(1) << RSH) / longint'(WAVE_LEN);
    localparam logic [PW-1:0] RECIP = PW'(RECIP_L);
    localparam longint LIMIT_L = longint'(WAVE_LEN) << FRAC_BITS;

    if (STEP_W > FRAC_BITS) begin : g_fold
        logic [IW-1:0] whole;
        logic [PW-1:0] prod;
        logic [IW-1:0] quo;
        logic [MW-1:0] rem_est;
        logic [MW-1:0] rem_fix;

        // Estimate the entry quotient, then correct the remainder once
        assign whole   = i_step[STEP_W-1:FRAC_BITS];
        assign prod    = PW'(whole) * RECIP;
        assign quo     = IW'(prod >> RSH);
        assign rem_est = MW'(whole) - MW'(quo) * MW'(WAVE_LEN);
        assign rem_fix = (rem_est >= MW'(WAVE_LEN)) ? rem_est - MW'(WAVE_LEN) : rem_est;
        assign o_rem   = {rem_fix[AW-1:0], i_step[FRAC_BITS-1:0]};
    end else begin : g_pass
        // Step is all fraction: already inside the range
        assign o_rem = PH_W'(i_step);
    end

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        longint'(o_rem) < LIMIT_L)
        else $error("reduced step left the phase range");

    a_frac_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rem[FRAC_BITS-1:0] == i_step[FRAC_BITS-1:0])
        else $error("reduced step lost its fraction");

    a_small_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (longint'(i_step) < LIMIT_L) |-> (longint'(o_rem) == longint'(i_step)))
        else $error("step inside the range was changed");

endmodule
